### src/bpt_pkg.sv
// Shared types, constants and helper functions for the barometer
// compensation block. No dependencies.
`timescale 1ns / 1ps

package bpt_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 55;

    typedef logic signed [57:0] acc_t;
    typedef logic signed [55:0] val_t;

    localparam acc_t ACC_POS = acc_t'({3'b000, {55{1'b1}}});
    localparam acc_t ACC_NEG = -ACC_POS;
    localparam logic [MUL_B_W-1:0] MAG_MAX = {MUL_B_W{1'b1}};

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    localparam logic [5:0] OVS_RESET = 6'd13;

    localparam logic [2:0] CFG_C0_C1   = 3'd0;
    localparam logic [2:0] CFG_C00     = 3'd1;
    localparam logic [2:0] CFG_C10     = 3'd2;
    localparam logic [2:0] CFG_C01_C11 = 3'd3;
    localparam logic [2:0] CFG_C20     = 3'd4;
    localparam logic [2:0] CFG_C21_C30 = 3'd5;
    localparam logic [2:0] CFG_OVS     = 3'd6;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        SP_T1,
        SP_A,
        SP_B,
        SP_C,
        SP_D,
        SP_E,
        SP_F,
        SP_G
    } step_t;

    typedef struct packed {
        logic               start;
        logic signed [23:0] raw;
        logic [22:0]        k;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic               frac;
        logic [MUL_A_W-1:0] a_mag;
        logic [MUL_B_W-1:0] b_mag;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_B_W-1:0] mag;
    } mul_rsp_t;

    function automatic logic [22:0] k_lookup(input logic [2:0] code);
        logic [22:0] k;
        case (code)
            3'd0:    k = 23'd524288;
            3'd1:    k = 23'd1572864;
            3'd2:    k = 23'd3670016;
            3'd3:    k = 23'd7864320;
            3'd4:    k = 23'd253952;
            3'd5:    k = 23'd516096;
            3'd6:    k = 23'd1040384;
            3'd7:    k = 23'd2088960;
            default: k = 23'd524288;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return m;
    endfunction

    function automatic logic [MUL_B_W-1:0] mag56(input val_t v);
        logic [55:0] m;
        m = v[55] ? (~v + 56'd1) : v;
        return m[MUL_B_W-1:0];
    endfunction

endpackage

### src/bpt_div.sv
// Radix-2 restoring divider: scales a raw reading by the oversampling factor,
// rounded half away from zero and saturated to 32 bits. Uses bpt_pkg.
`timescale 1ns / 1ps

module bpt_div #(
    parameter int FRAC_BITS = bpt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bpt_pkg::div_req_t req,
    output bpt_pkg::div_rsp_t rsp
);

    localparam int NW = FRAC_BITS + 24;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [22:0]   rem_reg, rem_next;
    logic [22:0]   k_reg, k_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [23:0]   raw_mag;
    logic [23:0]   trial;
    logic [23:0]   trial_sub;
    logic          fits;
    logic          ovf;
    logic [31:0]   quo_mag;

    always_comb
    begin
        raw_mag   = req.raw[23] ? (~req.raw + 24'd1) : req.raw;
        trial     = {rem_reg, num_reg[NW-1]};
        trial_sub = trial - {1'b0, k_reg};
        fits      = (trial >= {1'b0, k_reg});

        num_next  = num_reg;
        rem_next  = rem_reg;
        k_next    = k_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            num_next  = {raw_mag, {FRAC_BITS{1'b0}}} + NW'(req.k >> 1);
            rem_next  = '0;
            k_next    = req.k;
            neg_next  = req.raw[23];
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], fits};
            rem_next = fits ? trial_sub[22:0] : trial[22:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // quotient sits in num_reg once the last bit is shifted in
    always_comb
    begin
        ovf     = |num_reg[NW-1:31];
        quo_mag = num_reg[31:0];
        if (ovf)
            rsp.quo = neg_reg ? bpt_pkg::Q_MIN : bpt_pkg::Q_MAX;
        else
            rsp.quo = neg_reg ? (~quo_mag + 32'd1) : quo_mag;
        rsp.done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        k_reg   <= k_next;
        neg_reg <= neg_next;
    end

endmodule

### src/bpt_mul.sv
// Shift-add magnitude multiplier, one multiplier bit per cycle, with optional
// rounding of the product to FRAC_BITS fraction bits. Uses bpt_pkg.
`timescale 1ns / 1ps

module bpt_mul #(
    parameter int FRAC_BITS = bpt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bpt_pkg::mul_req_t req,
    output bpt_pkg::mul_rsp_t rsp
);

    localparam int AW = bpt_pkg::MUL_A_W;
    localparam int BW = bpt_pkg::MUL_B_W;
    localparam int PW = AW + BW;
    localparam int CW = $clog2(AW + 1);
    localparam int W1 = PW + 1 - FRAC_BITS;

    logic [PW-1:0] p_reg, p_next;
    logic [BW-1:0] b_reg, b_next;
    logic          frac_reg, frac_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [BW:0]   sum;
    logic [W1:0]   rnd;
    logic [W1-1:0] rval;

    always_comb
    begin
        sum       = {1'b0, p_reg[PW-1:AW]} + {1'b0, b_reg};
        p_next    = p_reg;
        b_next    = b_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            p_next    = {{BW{1'b0}}, req.a_mag};
            b_next    = req.b_mag;
            frac_next = req.frac;
            cnt_next  = CW'(AW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = p_reg[0] ? {sum, p_reg[AW-1:1]} : {1'b0, p_reg[PW-1:1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        rnd  = {1'b0, p_reg[PW-1:FRAC_BITS-1]} + (W1 + 1)'(1);
        rval = rnd[W1:1];
        if (frac_reg)
            rsp.mag = (|rval[W1-1:BW]) ? bpt_pkg::MAG_MAX : rval[BW-1:0];
        else
            rsp.mag = p_reg[BW-1:0];
        rsp.done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        b_reg    <= b_next;
        frac_reg <= frac_next;
    end

endmodule

### src/baro_pressure_temp_compensation.sv
// Top level: calibration registers, sequencer and output register of the
// barometer compensation block. Uses bpt_pkg, bpt_div and bpt_mul.
`timescale 1ns / 1ps

// One word in, one word out. The word is accepted in the idle state. The raw
// value goes through a radix-2 divider, one quotient bit per cycle over
// FRAC_BITS + 24 bits. Then one (temperature) or seven (pressure) products
// go in turn through a single shared multiplier. The done state loads the
// output register, and a stalled output register holds the block in that
// state. Words are taken one at a time; the next word is accepted while a
// finished result still waits in the output register. The stored scaled
// temperature resets to zero and is used by every pressure word.

module baro_pressure_temp_compensation #(
    parameter int FRAC_BITS = bpt_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_stall,
    input  logic               req_type,
    input  logic signed [23:0] raw_value,

    output logic               res_valid,
    input  logic               res_stall,
    output logic               result_kind,
    output logic signed [31:0] value,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int QS = FRAC_BITS - 8;
    localparam int QW = 56 - QS;

    bpt_pkg::state_t state_reg, state_next;
    bpt_pkg::step_t  step_reg;

    logic [23:0] cal_c0_c1_reg;
    logic [19:0] cal_c00_reg;
    logic [19:0] cal_c10_reg;
    logic [31:0] cal_c01_c11_reg;
    logic [15:0] cal_c20_reg;
    logic [31:0] cal_c21_c30_reg;
    logic [5:0]  ovs_reg;

    logic signed [31:0] tsc_reg;
    logic signed [31:0] psc_reg;
    bpt_pkg::val_t      x_reg;
    bpt_pkg::val_t      y_reg;
    bpt_pkg::val_t      res_reg;
    bpt_pkg::acc_t      acc_reg;
    logic               kind_reg;
    logic               neg_reg;

    logic               res_valid_reg;
    logic               result_kind_reg;
    logic signed [31:0] value_reg;

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;

    bpt_pkg::div_req_t div_req;
    bpt_pkg::div_rsp_t div_rsp;
    bpt_pkg::mul_req_t mul_req;
    bpt_pkg::mul_rsp_t mul_rsp;

    logic signed [31:0] a_sel;
    bpt_pkg::val_t      b_sel;
    logic               frac_sel;

    bpt_pkg::acc_t base;
    bpt_pkg::acc_t addend;
    bpt_pkg::acc_t prod_ext;
    bpt_pkg::acc_t prod_s;
    bpt_pkg::acc_t sum;
    bpt_pkg::val_t sat_sum;
    logic          last_step;

    logic          accept;
    logic          div_start;
    logic          mul_start;
    logic          out_load;

    logic [54:0]   q_vm;
    logic [QW:0]   q_rnd;
    logic [QW-1:0] q_m;
    logic [31:0]   q8;

    assign c0  = cal_c0_c1_reg[23:12];
    assign c1  = cal_c0_c1_reg[11:0];
    assign c00 = cal_c00_reg;
    assign c10 = cal_c10_reg;
    assign c01 = cal_c01_c11_reg[31:16];
    assign c11 = cal_c01_c11_reg[15:0];
    assign c20 = cal_c20_reg;
    assign c21 = cal_c21_c30_reg[31:16];
    assign c30 = cal_c21_c30_reg[15:0];

    assign cfg_ready = 1'b1;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_c0_c1_reg   <= '0;
            cal_c00_reg     <= '0;
            cal_c10_reg     <= '0;
            cal_c01_c11_reg <= '0;
            cal_c20_reg     <= '0;
            cal_c21_c30_reg <= '0;
            ovs_reg         <= bpt_pkg::OVS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpt_pkg::CFG_C0_C1:   cal_c0_c1_reg   <= cfg_data[23:0];
                bpt_pkg::CFG_C00:     cal_c00_reg     <= cfg_data[19:0];
                bpt_pkg::CFG_C10:     cal_c10_reg     <= cfg_data[19:0];
                bpt_pkg::CFG_C01_C11: cal_c01_c11_reg <= cfg_data;
                bpt_pkg::CFG_C20:     cal_c20_reg     <= cfg_data[15:0];
                bpt_pkg::CFG_C21_C30: cal_c21_c30_reg <= cfg_data;
                bpt_pkg::CFG_OVS:     ovs_reg         <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // ---- arithmetic units ----
    assign div_req.start = div_start;
    assign div_req.raw   = raw_value;
    assign div_req.k     = req_type ? bpt_pkg::k_lookup(ovs_reg[2:0])
                                    : bpt_pkg::k_lookup(ovs_reg[5:3]);

    bpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        case (step_reg)
            bpt_pkg::SP_T1:
            begin
                a_sel = tsc_reg; b_sel = bpt_pkg::val_t'(c1);  frac_sel = 1'b0;
            end
            bpt_pkg::SP_A:
            begin
                a_sel = psc_reg; b_sel = bpt_pkg::val_t'(c30); frac_sel = 1'b0;
            end
            bpt_pkg::SP_B:
            begin
                a_sel = psc_reg; b_sel = x_reg;                frac_sel = 1'b1;
            end
            bpt_pkg::SP_C:
            begin
                a_sel = psc_reg; b_sel = bpt_pkg::val_t'(c21); frac_sel = 1'b0;
            end
            bpt_pkg::SP_D:
            begin
                a_sel = tsc_reg; b_sel = x_reg;                frac_sel = 1'b1;
            end
            bpt_pkg::SP_E:
            begin
                a_sel = psc_reg; b_sel = x_reg;                frac_sel = 1'b1;
            end
            bpt_pkg::SP_F:
            begin
                a_sel = psc_reg; b_sel = y_reg;                frac_sel = 1'b1;
            end
            bpt_pkg::SP_G:
            begin
                a_sel = tsc_reg; b_sel = bpt_pkg::val_t'(c01); frac_sel = 1'b0;
            end
            default:
            begin
                a_sel = tsc_reg; b_sel = '0;                   frac_sel = 1'b0;
            end
        endcase
    end

    assign mul_req.start = mul_start;
    assign mul_req.frac  = frac_sel;
    assign mul_req.a_mag = bpt_pkg::mag32(a_sel);
    assign mul_req.b_mag = bpt_pkg::mag56(b_sel);

    bpt_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // ---- term accumulation ----
    always_comb
    begin
        case (step_reg)
            bpt_pkg::SP_T1: base = bpt_pkg::acc_t'(c0)  <<< (FRAC_BITS - 1);
            bpt_pkg::SP_A:  base = bpt_pkg::acc_t'(c20) <<< FRAC_BITS;
            bpt_pkg::SP_B:  base = bpt_pkg::acc_t'(c10) <<< FRAC_BITS;
            bpt_pkg::SP_C:  base = bpt_pkg::acc_t'(c11) <<< FRAC_BITS;
            bpt_pkg::SP_G:  base = bpt_pkg::acc_t'(c00) <<< FRAC_BITS;
            default:        base = '0;
        endcase

        if (step_reg == bpt_pkg::SP_F || step_reg == bpt_pkg::SP_G)
            addend = acc_reg;
        else
            addend = '0;

        prod_ext = bpt_pkg::acc_t'({3'b000, mul_rsp.mag});
        prod_s   = neg_reg ? -prod_ext : prod_ext;
        sum      = base + addend + prod_s;

        if (sum > bpt_pkg::ACC_POS)
            sat_sum = bpt_pkg::ACC_POS[55:0];
        else if (sum < bpt_pkg::ACC_NEG)
            sat_sum = bpt_pkg::ACC_NEG[55:0];
        else
            sat_sum = sum[55:0];

        last_step = (step_reg == bpt_pkg::SP_T1) || (step_reg == bpt_pkg::SP_G);
    end

    // ---- Q23.8 rounding of the final sum ----
    always_comb
    begin
        q_vm  = bpt_pkg::mag56(res_reg);
        q_rnd = {1'b0, q_vm[54:QS-1]} + (QW + 1)'(1);
        q_m   = q_rnd[QW:1];
        if (|q_m[QW-1:31])
            q8 = res_reg[55] ? bpt_pkg::Q_MIN : bpt_pkg::Q_MAX;
        else
            q8 = res_reg[55] ? (~q_m[31:0] + 32'd1) : q_m[31:0];
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpt_pkg::ST_IDLE:
                if (req_valid)
                    state_next = bpt_pkg::ST_DIV;
            bpt_pkg::ST_DIV:
                if (div_rsp.done)
                    state_next = bpt_pkg::ST_MUL_GO;
            bpt_pkg::ST_MUL_GO:
                state_next = bpt_pkg::ST_MUL_WAIT;
            bpt_pkg::ST_MUL_WAIT:
                if (mul_rsp.done)
                    state_next = last_step ? bpt_pkg::ST_DONE : bpt_pkg::ST_MUL_GO;
            bpt_pkg::ST_DONE:
                if (!res_valid_reg || !res_stall)
                    state_next = bpt_pkg::ST_IDLE;
            default:
                state_next = bpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        div_start = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            bpt_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                div_start = req_valid;
            end
            bpt_pkg::ST_MUL_GO:
                mul_start = 1'b1;
            bpt_pkg::ST_DONE:
                out_load = !res_valid_reg || !res_stall;
            default: ;
        endcase
    end

    assign accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpt_pkg::ST_IDLE;
            step_reg      <= bpt_pkg::SP_T1;
            tsc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (div_rsp.done)
            begin
                step_reg <= (kind_reg == bpt_pkg::KIND_PRESS) ? bpt_pkg::SP_A
                                                              : bpt_pkg::SP_T1;
                if (kind_reg == bpt_pkg::KIND_TEMP)
                    tsc_reg <= div_rsp.quo;
            end
            else if (mul_rsp.done)
            begin
                case (step_reg)
                    bpt_pkg::SP_A: step_reg <= bpt_pkg::SP_B;
                    bpt_pkg::SP_B: step_reg <= bpt_pkg::SP_C;
                    bpt_pkg::SP_C: step_reg <= bpt_pkg::SP_D;
                    bpt_pkg::SP_D: step_reg <= bpt_pkg::SP_E;
                    bpt_pkg::SP_E: step_reg <= bpt_pkg::SP_F;
                    bpt_pkg::SP_F: step_reg <= bpt_pkg::SP_G;
                    default:       step_reg <= step_reg;
                endcase
            end

            if (out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            kind_reg <= req_type;

        if (div_rsp.done && kind_reg == bpt_pkg::KIND_PRESS)
            psc_reg <= div_rsp.quo;

        if (mul_start)
            neg_reg <= a_sel[31] ^ b_sel[55];

        if (mul_rsp.done)
        begin
            case (step_reg)
                bpt_pkg::SP_T1: res_reg <= sat_sum;
                bpt_pkg::SP_A:  x_reg   <= sat_sum;
                bpt_pkg::SP_B:  y_reg   <= sat_sum;
                bpt_pkg::SP_C:  x_reg   <= sat_sum;
                bpt_pkg::SP_D:  x_reg   <= sat_sum;
                bpt_pkg::SP_E:  acc_reg <= sum;
                bpt_pkg::SP_F:  acc_reg <= sum;
                bpt_pkg::SP_G:  res_reg <= sat_sum;
                default: ;
            endcase
        end

        if (out_load)
        begin
            result_kind_reg <= kind_reg;
            value_reg       <= q8;
        end
    end

    assign res_valid   = res_valid_reg;
    assign result_kind = result_kind_reg;
    assign value       = value_reg;

    // ---- assertions ----
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == bpt_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> state_reg == bpt_pkg::ST_MUL_WAIT)
        else $error("multiplier finished outside the wait state");

    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg) == bpt_pkg::ST_DONE)
        else $error("result word raised without a finished item");

    a_tsc_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tsc_reg) |-> $past(div_rsp.done) && $past(kind_reg) == bpt_pkg::KIND_TEMP)
        else $error("stored temperature changed outside a temperature word");

endmodule

### test/tb_baro_pressure_temp_compensation.sv
// Self-checking testbench for baro_pressure_temp_compensation: directed and random
// temperature/pressure words checked against an in-bench fixed-point predictor.
// Depends on bpt_pkg and the compensation block RTL only.
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation;
    import bpt_pkg::*;

    typedef longint unsigned u64_t;

    localparam int         FB            = FRAC_BITS_DEF;
    localparam longint     ACC_LIM       = (longint'(1) <<< 55) - 1;
    localparam longint     ONE           = longint'(1) <<< FB;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 320;
    localparam logic [2:0] CFG_UNUSED    = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [31:0] val;
    } comp_word_t;

    typedef struct packed {
        logic        kind;
        logic [23:0] raw;
    } raw_word_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_stall;
    logic               req_type    = 1'b0;
    logic signed [23:0] raw_value   = '0;
    logic               res_valid;
    logic               res_stall   = 1'b0;
    logic               result_kind;
    logic signed [31:0] value;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index   = '0;
    logic [31:0]        cfg_data    = '0;

    raw_word_t   word_q[$];
    comp_word_t  comp_q[$];
    raw_word_t   next_word;
    comp_word_t  head;
    logic [31:0] cal_regs [0:6];
    int          temp_scaled;
    int          words_pending = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          long_gap      = 0;
    int          err_count     = 0;
    int          cycle_count   = 0;

    baro_pressure_temp_compensation dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .raw_value   (raw_value),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .result_kind (result_kind),
        .value       (value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic u64_t magnitude(input longint v);
        u64_t m;
        m = (v < 0) ? -v : v;
        return m;
    endfunction

    function automatic int sat_q32(input bit neg, input u64_t m);
        if (neg)
        begin
            if (m >= 64'h8000_0000)
                return int'(Q_MIN);
            return int'(-longint'(m));
        end
        if (m > 64'h7FFF_FFFF)
            return int'(Q_MAX);
        return int'(m);
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_LIM)
            return ACC_LIM;
        if (v < -ACC_LIM)
            return -ACC_LIM;
        return v;
    endfunction

    function automatic u64_t osr_divisor(input logic [2:0] code);
        u64_t d;
        case (code)
            3'd0:    d = 524288;
            3'd1:    d = 1572864;
            3'd2:    d = 3670016;
            3'd3:    d = 7864320;
            3'd4:    d = 253952;
            3'd5:    d = 516096;
            3'd6:    d = 1040384;
            default: d = 2088960;
        endcase
        return d;
    endfunction

    function automatic int scale_raw(input logic signed [23:0] raw, input logic [2:0] code);
        u64_t num;
        u64_t div;
        u64_t quo;
        div = osr_divisor(code);
        num = magnitude(longint'(raw)) << FB;
        quo = (num + (div >> 1)) / div;
        return sat_q32(raw < 0, quo);
    endfunction

    // x*y / 2^FB, |x| <= 2^31, |y| <= ACC_LIM
    function automatic longint fix_mul(input longint x, input longint y);
        bit   neg;
        u64_t mx;
        u64_t my;
        u64_t ph;
        u64_t pl;
        u64_t r;
        neg = (x < 0) != (y < 0);
        mx  = magnitude(x);
        my  = magnitude(y);
        ph  = mx * (my >> 32);
        pl  = mx * (my & 64'hFFFF_FFFF);
        if (ph > u64_t'(ACC_LIM >> (32 - FB)))
            r = ACC_LIM;
        else
        begin
            r = (ph << (32 - FB)) + ((pl + (64'd1 << (FB - 1))) >> FB);
            if (r > u64_t'(ACC_LIM))
                r = ACC_LIM;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic int to_q8(input longint v);
        u64_t m;
        m = (magnitude(v) + (64'd1 << (FB - 9))) >> (FB - 8);
        return sat_q32(v < 0, m);
    endfunction

    function automatic comp_word_t compensate(input logic kind, input logic signed [23:0] raw);
        longint     c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint     tsc, psc, a, b, c, p;
        comp_word_t w;
        w.kind = kind;
        if (kind == KIND_TEMP)
        begin
            c0 = longint'($signed(cal_regs[CFG_C0_C1][23:12]));
            c1 = longint'($signed(cal_regs[CFG_C0_C1][11:0]));
            temp_scaled = scale_raw(raw, cal_regs[CFG_OVS][5:3]);
            w.val = to_q8(clamp_acc(c0 * (ONE / 2) + c1 * longint'(temp_scaled)));
        end
        else
        begin
            c00 = longint'($signed(cal_regs[CFG_C00][19:0]));
            c10 = longint'($signed(cal_regs[CFG_C10][19:0]));
            c01 = longint'($signed(cal_regs[CFG_C01_C11][31:16]));
            c11 = longint'($signed(cal_regs[CFG_C01_C11][15:0]));
            c20 = longint'($signed(cal_regs[CFG_C20][15:0]));
            c21 = longint'($signed(cal_regs[CFG_C21_C30][31:16]));
            c30 = longint'($signed(cal_regs[CFG_C21_C30][15:0]));
            tsc = longint'(temp_scaled);
            psc = longint'(scale_raw(raw, cal_regs[CFG_OVS][2:0]));
            a = clamp_acc(c20 * ONE + c30 * psc);
            b = clamp_acc(c10 * ONE + fix_mul(psc, a));
            c = clamp_acc(c11 * ONE + c21 * psc);
            p = clamp_acc(c00 * ONE + fix_mul(psc, b) + c01 * tsc
                          + fix_mul(psc, fix_mul(tsc, c)));
            w.val = to_q8(p);
        end
        return w;
    endfunction

    function automatic logic [23:0] pick_raw();
        logic signed [19:0] mid;
        logic signed [8:0]  tiny;
        mid  = 20'($urandom);
        tiny = 9'($urandom);
        case ($urandom_range(7))
            0, 1:    return 24'($urandom);
            6:
            begin
                case ($urandom_range(4))
                    0:       return 24'h7F_FFFF;
                    1:       return 24'h80_0000;
                    2:       return 24'h00_0000;
                    3:       return 24'hFF_FFFF;
                    default: return 24'h00_0001;
                endcase
            end
            7:       return {{15{tiny[8]}}, tiny};
            default: return {{4{mid[19]}}, mid};
        endcase
    endfunction

    // word driver: payload held while stalled
    always @(posedge clk)
    begin
        if (rst_n && (!req_valid || !req_stall))
        begin
            if (long_gap > 0)
            begin
                long_gap  = long_gap - 1;
                req_valid <= 1'b0;
            end
            else if (word_q.size() == 0 || $urandom_range(99) < send_idle_pct)
                req_valid <= 1'b0;
            else
            begin
                next_word = word_q.pop_front();
                req_valid <= 1'b1;
                req_type  <= next_word.kind;
                raw_value <= next_word.raw;
                if (send_idle_pct != 0 && $urandom_range(19) == 0)
                    long_gap = $urandom_range(320, 1);
            end
        end
    end

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (comp_q.size() == 0)
                begin
                    $error("unexpected result word: result_kind %0d value %0d",
                           result_kind, value);
                    err_count++;
                end
                else
                begin
                    head = comp_q.pop_front();
                    if (result_kind !== head.kind)
                    begin
                        $error("result_kind expected %0d actual %0d", head.kind, result_kind);
                        err_count++;
                    end
                    if (value !== head.val)
                    begin
                        $error("value expected %0d actual %0d", $signed(head.val), value);
                        err_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                comp_q.push_back(compensate(req_type, raw_value));
                words_pending--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic kind, input logic [23:0] raw);
        raw_word_t w;
        w.kind = kind;
        w.raw  = raw;
        word_q.push_back(w);
        words_pending++;
    endtask

    task automatic wait_quiet();
        while (words_pending != 0 || comp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_C0_C1:              cal_regs[idx] = data & 32'h00FF_FFFF;
            CFG_C00, CFG_C10:       cal_regs[idx] = data & 32'h000F_FFFF;
            CFG_C01_C11, CFG_C21_C30: cal_regs[idx] = data;
            CFG_C20:                cal_regs[idx] = data & 32'h0000_FFFF;
            CFG_OVS:                cal_regs[idx] = data & 32'h0000_003F;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cal(input logic [23:0] c0_c1, input logic [31:0] c00,
                            input logic [31:0] c10, input logic [31:0] c01_c11,
                            input logic [31:0] c20, input logic [31:0] c21_c30);
        write_reg(CFG_C0_C1, {8'h00, c0_c1});
        write_reg(CFG_C00, c00);
        write_reg(CFG_C10, c10);
        write_reg(CFG_C01_C11, c01_c11);
        write_reg(CFG_C20, c20);
        write_reg(CFG_C21_C30, c21_c30);
    endtask

    task automatic load_typical_cal();
        load_cal({12'h0CC, 12'hEFB}, 32'sd80469, -32'sd54769,
                 {-16'sd2803, 16'sd1491}, -32'sd10113, {16'sd125, -16'sd1385});
    endtask

    // stored temperature is still zero from reset
    task automatic test_pressure_before_temp();
        load_typical_cal();
        send_word(KIND_PRESS, 24'hF1_2345);
        send_word(KIND_TEMP, 24'hFC_8A11);
        wait_quiet();
    endtask

    task automatic test_field_extremes();
        send_word(KIND_TEMP, 24'h00_0000);
        send_word(KIND_PRESS, 24'h00_0000);
        send_word(KIND_TEMP, 24'h7F_FFFF);
        send_word(KIND_PRESS, 24'h7F_FFFF);
        send_word(KIND_TEMP, 24'h80_0000);
        send_word(KIND_PRESS, 24'h80_0000);
        send_word(KIND_TEMP, 24'hFF_FFFF);
        send_word(KIND_PRESS, 24'hFF_FFFF);
        send_word(KIND_TEMP, 24'h00_0001);
        send_word(KIND_PRESS, 24'h00_0001);
        wait_quiet();
    endtask

    // new codes apply to later words only, stored temperature kept as is
    task automatic test_code_change();
        send_word(KIND_TEMP, 24'h0A_5B3C);
        wait_quiet();
        write_reg(CFG_OVS, 32'h0000_0038);
        send_word(KIND_PRESS, 24'hF4_0101);
        send_word(KIND_TEMP, 24'h0A_5B3C);
        send_word(KIND_PRESS, 24'hF4_0101);
        wait_quiet();
    endtask

    task automatic test_reg_edges();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_C00, 32'hABC0_1234);
        write_reg(CFG_C20, 32'h5A5A_8001);
        send_word(KIND_TEMP, 24'h12_3456);
        send_word(KIND_PRESS, 24'hED_CBA9);
        wait_quiet();
    endtask

    task automatic test_saturation();
        load_cal({12'h7FF, 12'h7FF}, 32'h0007_FFFF, 32'h0007_FFFF,
                 32'h7FFF_7FFF, 32'h0000_7FFF, 32'h7FFF_7FFF);
        write_reg(CFG_OVS, 32'h0000_0024);
        send_word(KIND_TEMP, 24'h7F_FFFF);
        send_word(KIND_PRESS, 24'h7F_FFFF);
        send_word(KIND_PRESS, 24'h80_0000);
        wait_quiet();
        load_cal({12'h800, 12'h800}, 32'h0008_0000, 32'h0008_0000,
                 32'h8000_8000, 32'h0000_8000, 32'h8000_8000);
        send_word(KIND_TEMP, 24'h80_0000);
        send_word(KIND_PRESS, 24'h7F_FFFF);
        send_word(KIND_PRESS, 24'h80_0000);
        wait_quiet();
    endtask

    task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(CFG_C0_C1, $urandom);
        write_reg(CFG_C00, $urandom);
        write_reg(CFG_C10, $urandom);
        write_reg(CFG_C01_C11, $urandom);
        write_reg(CFG_C20, $urandom);
        write_reg(CFG_C21_C30, $urandom);
        write_reg(CFG_OVS, $urandom);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                wait_quiet();
            send_word(1'($urandom_range(1)), pick_raw());
        end
        wait_quiet();
    endtask

    initial
    begin
        for (int i = 0; i < 7; i++)
            cal_regs[i] = '0;
        cal_regs[CFG_OVS] = {26'd0, OVS_RESET};
        temp_scaled = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pressure_before_temp();
        test_field_extremes();
        test_code_change();
        test_reg_edges();
        test_saturation();
        test_random_phase(100, 7, 88);
        test_random_phase(100, 88, 7);
        test_random_phase(100, 0, 0);
        test_random_phase(100, 0, 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
src/bpt_pkg.sv
src/bpt_div.sv
src/bpt_mul.sv
src/baro_pressure_temp_compensation.sv
test/tb_baro_pressure_temp_compensation.sv
